/* hw/rtl/mfss_pkg.sv */
package mfss_pkg;

	// Default sizes of the frequency store and the seed limit.
	localparam int MAX_READ_LENGTH_DEF = 256;
	localparam int MAX_SEEDS_DEF       = 32;

	// Field widths.
	localparam int FREQ_W  = 32;
	localparam int TOTAL_W = 37;
	localparam int RLEN_W  = 9;
	localparam int SCNT_W  = 6;
	localparam int SLEN_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Saturation value of every running sum.
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Reset values of the configuration registers.
	localparam logic [RLEN_W-1:0] READ_LENGTH_RST = RLEN_W'(100);
	localparam logic [SCNT_W-1:0] SEED_COUNT_RST  = SCNT_W'(5);
	localparam logic [SLEN_W-1:0] SEED_LENGTH_RST = SLEN_W'(12);

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_READ_LENGTH = 2'd0,
		REG_SEED_COUNT  = 2'd1,
		REG_SEED_LENGTH = 2'd2
	} reg_idx_t;

	// Sequencer states: loading frequencies, reading one cell, updating one cell.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_CALC
	} state_t;

endpackage

/* hw/rtl/min_frequency_seed_selection_dp_core.sv */
// Minimum-frequency seed selection. Seed frequencies of one read arrive one per start position,
// read_length - seed_length + 1 transfers in all. The transfer of the last frequency starts the
// seed-placement dynamic program, which runs on one shared saturating add-and-compare unit over
// a single cost row held in memory: every cell is a memory read, then the update and write-back,
// for seed_count rows of W = read_length + 1 - seed_count * seed_length cells, and the input
// is not ready meanwhile. There is no clearing pass; the first row uses zeros in place of the
// stored row. The result, the minimum total frequency of seed_count non-overlapping seeds,
// waits in an output register while the next read loads. With an unusable configuration
// (a zero register, a read longer than the store, too many seeds, or seeds that do not fit)
// every transfer returns at once a result with config_error set and a total of zero. Any
// register write drops a partly loaded read.
module min_frequency_seed_selection_dp_core #(
	parameter int MAX_READ_LENGTH = mfss_pkg::MAX_READ_LENGTH_DEF,
	parameter int MAX_SEEDS       = mfss_pkg::MAX_SEEDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mfss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mfss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mfss_pkg::FREQ_W-1:0]       seed_frequency,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mfss_pkg::TOTAL_W-1:0]      min_total_frequency,
	output logic                              config_error
);

	localparam int AW = $clog2(MAX_READ_LENGTH);
	localparam int DW = (AW + 1 > 16) ? AW + 1 : 16;
	localparam int FW = mfss_pkg::FREQ_W;
	localparam int TW = mfss_pkg::TOTAL_W;

	// Configuration registers.
	logic [mfss_pkg::RLEN_W-1:0] read_length_q;
	logic [mfss_pkg::SCNT_W-1:0] seed_count_q;
	logic [mfss_pkg::SLEN_W-1:0] seed_length_q;

	// Sequencer and counters.
	mfss_pkg::state_t            state_q, state_d;
	logic [AW-1:0]               pos_q;
	logic [mfss_pkg::SCNT_W-1:0] row_q;
	logic [AW-1:0]               col_q;
	logic [AW-1:0]               base_q;

	// Memories and their registered read data.
	logic [FW-1:0] freq_mem [MAX_READ_LENGTH];
	logic [TW-1:0] cost_mem [MAX_READ_LENGTH];
	logic [FW-1:0] freq_rd_q;
	logic [TW-1:0] cost_rd_q;
	logic [TW-1:0] left_q;

	// Output register.
	logic          out_valid_q;
	logic [TW-1:0] out_total_q;
	logic          out_err_q;

	// Derived configuration values.
	logic [DW-1:0] rlen_ext;
	logic [DW-1:0] span;
	logic [DW-1:0] total_items;
	logic [DW-1:0] row_width;
	logic          cfg_ok;
	logic          last_item;
	logic          last_col;
	logic          last_row;

	// Handshake and control.
	logic          emit_on_load;
	logic          in_fire;
	logic          load_wr;
	logic          start_solve;
	logic          err_emit;
	logic          solve_emit;
	logic [AW-1:0] freq_addr;

	// Shared add-and-compare unit.
	logic [TW-1:0] prev_cost;
	logic [TW:0]   sum;
	logic [TW-1:0] cand;
	logic [TW-1:0] new_cost;

	// Validity of the configuration and the sizes of the read and the row.
	always_comb begin
		rlen_ext    = DW'(read_length_q);
		span        = DW'(seed_count_q) * DW'(seed_length_q);
		total_items = rlen_ext - DW'(seed_length_q) + DW'(1);
		row_width   = rlen_ext + DW'(1) - span;
		cfg_ok      = (read_length_q != '0) && (seed_count_q != '0) && (seed_length_q != '0)
		           && (rlen_ext <= DW'(MAX_READ_LENGTH))
		           && (int'(seed_count_q) <= MAX_SEEDS)
		           && (span <= rlen_ext);
		last_item   = (DW'(pos_q) + DW'(1)) == total_items;
		last_col    = DW'(col_q) == (row_width - DW'(1));
		last_row    = row_q == seed_count_q;
	end

	// One cell update: saturating add of the frequency, then the minimum with the left cell.
	// The first row stands on an all-zero row, and column zero has no left neighbour.
	always_comb begin
		prev_cost = (row_q == mfss_pkg::SCNT_W'(1)) ? '0 : cost_rd_q;
		sum       = {1'b0, prev_cost} + (TW + 1)'(freq_rd_q);
		cand      = sum[TW] ? mfss_pkg::TOTAL_MAX : sum[TW-1:0];
		if (col_q == '0) begin
			new_cost = cand;
		end else begin
			new_cost = (left_q < cand) ? left_q : cand;
		end
	end

	assign freq_addr = base_q + col_q;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfss_pkg::ST_LOAD: begin
				if (start_solve) begin
					state_d = mfss_pkg::ST_READ;
				end
			end
			mfss_pkg::ST_READ: begin
				state_d = mfss_pkg::ST_CALC;
			end
			mfss_pkg::ST_CALC: begin
				state_d = (last_col && last_row) ? mfss_pkg::ST_LOAD : mfss_pkg::ST_READ;
			end
			default: begin
				state_d = mfss_pkg::ST_LOAD;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		emit_on_load = !cfg_ok || last_item;
		in_ready     = (state_q == mfss_pkg::ST_LOAD) && (!out_valid_q || !emit_on_load);
		in_fire      = in_valid && in_ready;
		load_wr      = in_fire && cfg_ok;
		start_solve  = load_wr && last_item;
		err_emit     = in_fire && !cfg_ok;
		solve_emit   = (state_q == mfss_pkg::ST_CALC) && last_col && last_row;
	end

	// Configuration registers; any write drops a partly loaded read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_length_q <= mfss_pkg::READ_LENGTH_RST;
			seed_count_q  <= mfss_pkg::SEED_COUNT_RST;
			seed_length_q <= mfss_pkg::SEED_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfss_pkg::REG_READ_LENGTH: read_length_q <= cfg_data[mfss_pkg::RLEN_W-1:0];
				mfss_pkg::REG_SEED_COUNT:  seed_count_q  <= cfg_data[mfss_pkg::SCNT_W-1:0];
				mfss_pkg::REG_SEED_LENGTH: seed_length_q <= cfg_data[mfss_pkg::SLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state, load position and the row and column counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfss_pkg::ST_LOAD;
			pos_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && (cfg_index == mfss_pkg::REG_READ_LENGTH
			            || cfg_index == mfss_pkg::REG_SEED_COUNT
			            || cfg_index == mfss_pkg::REG_SEED_LENGTH)) begin
				pos_q <= '0;
			end else if (load_wr) begin
				pos_q <= last_item ? '0 : pos_q + AW'(1);
			end else if (err_emit) begin
				pos_q <= '0;
			end
			if (start_solve) begin
				row_q  <= mfss_pkg::SCNT_W'(1);
				col_q  <= '0;
				base_q <= '0;
			end else if (state_q == mfss_pkg::ST_CALC) begin
				if (last_col) begin
					row_q  <= row_q + mfss_pkg::SCNT_W'(1);
					col_q  <= '0;
					base_q <= AW'(DW'(base_q) + DW'(seed_length_q));
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// Frequency store: written while loading, read once per cell.
	always_ff @(posedge clk) begin
		if (load_wr) begin
			freq_mem[pos_q] <= seed_frequency;
		end
		if (state_q == mfss_pkg::ST_READ) begin
			freq_rd_q <= freq_mem[freq_addr];
		end
	end

	// Cost row: read before each cell update, rewritten in place by it.
	always_ff @(posedge clk) begin
		if (state_q == mfss_pkg::ST_CALC) begin
			cost_mem[col_q] <= new_cost;
			left_q          <= new_cost;
		end
		if (state_q == mfss_pkg::ST_READ) begin
			cost_rd_q <= cost_mem[col_q];
		end
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_emit || solve_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (err_emit) begin
			out_total_q <= '0;
			out_err_q   <= 1'b1;
		end else if (solve_emit) begin
			out_total_q <= new_cost;
			out_err_q   <= 1'b0;
		end
	end

	assign out_valid           = out_valid_q;
	assign min_total_frequency = out_total_q;
	assign config_error        = out_err_q;

endmodule

/* hw/rtl/mfss_checker.sv */
module mfss_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [mfss_pkg::TOTAL_W-1:0]      min_total_frequency,
	input logic                              config_error
);

	// A result that is not taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_total_frequency)
		                            && $stable(config_error))
		else $error("result changed or dropped before its transfer");

	// An error result always carries a zero total.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> min_total_frequency == '0)
		else $error("error result with a non-zero total");

	// An error result appears only in the cycle after an input transfer.
	a_err_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && config_error |-> $past(in_valid && in_ready))
		else $error("error result without a preceding input transfer");

	// Reset leaves no result on offer.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind min_frequency_seed_selection_dp_core mfss_checker u_mfss_checker (.*);

/* verif/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mfss_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 64;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 600;
	localparam int LARGE_PHASE   = 5;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               err;
	} seed_total_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
		logic [FREQ_W-1:0]     freq;
		logic                  typed;
		logic [TOTAL_W-1:0]    total;
		logic                  err;
	} drill_row_t;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

	typedef enum logic [2:0] {
		FLAW_READ_ZERO,
		FLAW_COUNT_ZERO,
		FLAW_LENGTH_ZERO,
		FLAW_READ_LONG,
		FLAW_COUNT_HIGH,
		FLAW_OVERFULL
	} flaw_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [FREQ_W-1:0]     seed_frequency;
	logic                  out_valid;
	logic                  out_ready;
	logic [TOTAL_W-1:0]    min_total_frequency;
	logic                  config_error;

	// Shadow copy of the block's configuration and loaded frequencies.
	logic [RLEN_W-1:0]  shadow_read_len;
	logic [SCNT_W-1:0]  shadow_seed_cnt;
	logic [SLEN_W-1:0]  shadow_seed_len;
	logic [FREQ_W-1:0]  shadow_freq [MAX_READ_LENGTH_DEF];
	int                 shadow_loaded;

	seed_total_t best_totals_due [$];
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          burst_left  = 0;
	int          cycle_count = 0;
	bit          hold_wanted = 1'b0;

	// Directed rows. Typed expectations stand only where the answer is obvious;
	// the other rows are checked against the shadow computation.
	drill_row_t drill [$] = '{
		'{ROW_CFG,  REG_SEED_COUNT,  9'd0,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'hA5A5A5A5, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_SEED_COUNT,  9'd33,  32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h5A5A5A5A, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_SEED_COUNT,  9'd1,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd257, 32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'hFFFFFFFF, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd511, 32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h00000000, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd0,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h00000001, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd1,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h80000000, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_SEED_LENGTH, 9'd0,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h7FFFFFFF, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_SEED_LENGTH, 9'd2,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h00000002, 1'b1, 37'h0,          1'b1},
		'{ROW_CFG,  REG_SEED_LENGTH, 9'd1,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'hFFFFFFFF, 1'b1, 37'h0_FFFFFFFF, 1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h00000000, 1'b1, 37'h0,          1'b0},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd2,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_SEED_COUNT,  9'd2,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'hFFFFFFFF, 1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'hFFFFFFFF, 1'b1, 37'h1_FFFFFFFE, 1'b0},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd4,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd7,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd9,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_SEED_LENGTH, 9'd1,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd10,       1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd20,       1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd30,       1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd40,       1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd1,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd2,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_UNMAPPED,    9'h1FF, 32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd3,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'd4,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_READ_LENGTH, 9'd256, 32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_SEED_LENGTH, 9'd256, 32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_CFG,  REG_SEED_COUNT,  9'd1,   32'h0,        1'b0, 37'h0,          1'b0},
		'{ROW_ITEM, REG_UNMAPPED,    9'd0,   32'h12345678, 1'b1, 37'h0_12345678, 1'b0}
	};

	min_frequency_seed_selection_dp_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.seed_frequency      (seed_frequency),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.min_total_frequency (min_total_frequency),
		.config_error        (config_error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A configuration is usable only if every register is non-zero, within limits,
	// and the seeds fit in the read.
	function automatic bit seeds_fit();
		if (shadow_read_len == '0 || shadow_seed_cnt == '0 || shadow_seed_len == '0)
			return 1'b0;
		if (int'(shadow_read_len) > MAX_READ_LENGTH_DEF || int'(shadow_seed_cnt) > MAX_SEEDS_DEF)
			return 1'b0;
		return int'(shadow_seed_cnt) * int'(shadow_seed_len) <= int'(shadow_read_len);
	endfunction

	function automatic logic [TOTAL_W-1:0] add_clamped(input logic [TOTAL_W-1:0] a,
			input logic [FREQ_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {{(TOTAL_W + 1 - FREQ_W){1'b0}}, b};
		return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	// Seed placement over one cost row, updated in place row after row.
	// The row before the first seed is all zeros.
	function automatic logic [TOTAL_W-1:0] cheapest_placement();
		logic [TOTAL_W-1:0] row [MAX_READ_LENGTH_DEF];
		logic [TOTAL_W-1:0] cand;
		int width, base, h, w;
		width = int'(shadow_read_len) + 1 - int'(shadow_seed_cnt) * int'(shadow_seed_len);
		for (w = 0; w < width; w++)
			row[w] = '0;
		for (h = 1; h <= int'(shadow_seed_cnt); h++) begin
			base   = (h - 1) * int'(shadow_seed_len);
			row[0] = add_clamped(row[0], shadow_freq[base]);
			for (w = 1; w < width; w++) begin
				cand   = add_clamped(row[w], shadow_freq[base + w]);
				row[w] = (row[w - 1] < cand) ? row[w - 1] : cand;
			end
		end
		return row[width - 1];
	endfunction

	// Takes one frequency into the shadow state; returns 1 when it completes a result.
	function automatic bit absorb_frequency(input logic [FREQ_W-1:0] f, output seed_total_t r);
		r = '0;
		if (!seeds_fit()) begin
			shadow_loaded = 0;
			r.err         = 1'b1;
			return 1'b1;
		end
		shadow_freq[shadow_loaded] = f;
		shadow_loaded++;
		if (shadow_loaded < int'(shadow_read_len) - int'(shadow_seed_len) + 1)
			return 1'b0;
		r.total       = cheapest_placement();
		shadow_loaded = 0;
		return 1'b1;
	endfunction

	function automatic logic [FREQ_W-1:0] random_frequency();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return FREQ_W'($urandom_range(0, 15));
			5, 6:    return FREQ_W'($urandom_range(0, 1000));
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Offers one frequency in bursts with random gaps, and records the expected
	// result once the transfer has taken place.
	task automatic offer_frequency(input logic [FREQ_W-1:0] f, input bit typed,
			input seed_total_t typed_total);
		seed_total_t due;
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		seed_frequency <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (absorb_frequency(f, due) || typed)
			best_totals_due.push_back(typed ? typed_total : due);
	endtask

	// Any write to a real register drops a partly loaded read.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_READ_LENGTH: begin
				shadow_read_len = value;
				shadow_loaded   = 0;
			end
			REG_SEED_COUNT: begin
				shadow_seed_cnt = value[SCNT_W-1:0];
				shadow_loaded   = 0;
			end
			REG_SEED_LENGTH: begin
				shadow_seed_len = value;
				shadow_loaded   = 0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Waits until every expected result has arrived and the block has settled.
	task automatic await_quiet();
		while (best_totals_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus: directed rows first, then random phases of configuration and reads.
	initial begin : stimulus
		logic [CFG_DATA_W-1:0] setting [3];
		reg_idx_t idx;
		flaw_t    flaw;
		int phase, k, start, pick, read_items, reads, rl, sc, sl;

		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= REG_READ_LENGTH;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		seed_frequency <= '0;
		shadow_read_len = READ_LENGTH_RST;
		shadow_seed_cnt = SEED_COUNT_RST;
		shadow_seed_len = SEED_LENGTH_RST;
		shadow_loaded   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			if (drill[i].kind == ROW_CFG) begin
				in_valid <= 1'b0;
				await_quiet();
				write_register(drill[i].index, drill[i].value);
			end else begin
				offer_frequency(drill[i].freq, drill[i].typed,
					seed_total_t'{drill[i].total, drill[i].err});
			end
		end

		for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
			in_valid <= 1'b0;
			await_quiet();

			// Phase 1 runs an unusable setting and phase 2 a small one, both under a
			// long receiver hold-off; one phase uses the largest read and seed count.
			pick = $urandom_range(0, 99);
			if (phase == 1)
				pick = 99;
			else if (phase == 2)
				pick = 0;
			rl = $urandom_range(2, 24);
			sl = $urandom_range(1, (rl < 8) ? rl : 8);
			sc = $urandom_range(1, rl / sl);
			if (phase == LARGE_PHASE) begin
				rl = MAX_READ_LENGTH_DEF;
				sc = MAX_SEEDS_DEF;
				sl = ($urandom_range(0, 1) == 1) ? 1 : 8;
			end else if (pick < 55) begin
				// Small read; already chosen above.
			end else if (pick < 67) begin
				sc = MAX_SEEDS_DEF;
				sl = 1;
				rl = $urandom_range(32, 48);
			end else if (pick < 77) begin
				rl = $urandom_range(200, MAX_READ_LENGTH_DEF);
				sl = $urandom_range(rl - 16, rl);
				sc = 1;
			end else begin
				flaw = (pick == 99) ? FLAW_OVERFULL : flaw_t'($urandom_range(0, 5));
				case (flaw)
					FLAW_READ_ZERO:   rl = 0;
					FLAW_COUNT_ZERO:  sc = 0;
					FLAW_LENGTH_ZERO: sl = 0;
					FLAW_READ_LONG:   rl = $urandom_range(MAX_READ_LENGTH_DEF + 1, 511);
					FLAW_COUNT_HIGH:  sc = $urandom_range(MAX_SEEDS_DEF + 1, 63);
					default:          sc = rl / sl + 1;
				endcase
			end
			setting[REG_READ_LENGTH] = CFG_DATA_W'(rl);
			setting[REG_SEED_COUNT]  = CFG_DATA_W'(sc);
			setting[REG_SEED_LENGTH] = CFG_DATA_W'(sl);

			start = $urandom_range(0, 2);
			for (k = 0; k < 3; k++) begin
				idx = reg_idx_t'((start + k) % 3);
				write_register(idx, setting[idx]);
			end

			if (phase == 1 || phase == 2)
				hold_wanted = 1'b1;

			// Mostly whole reads; now and then a truncated one that the next write drops.
			if (seeds_fit()) begin
				read_items = int'(shadow_read_len) - int'(shadow_seed_len) + 1;
				reads      = (phase == LARGE_PHASE) ? 1 : $urandom_range(1, 48 / read_items + 1);
				repeat (reads)
					repeat (read_items)
						offer_frequency(random_frequency(), 1'b0, '0);
				if (read_items > 1 && $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, read_items - 1))
						offer_frequency(random_frequency(), 1'b0, '0);
			end else begin
				repeat ($urandom_range(3, 24))
					offer_frequency(random_frequency(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		await_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: stalls on its own pattern, with long hold-offs on request.
	initial begin : receiver
		rx_mode_t mode;
		int span_left, hold_left;
		mode      = RX_STEADY;
		span_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_left   = HOLD_CYCLES;
			end
			if (span_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 2));
				span_left = $urandom_range(4, 60);
			end
			span_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_STEADY: out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Each result transfer is compared field by field with the oldest expectation.
	always @(posedge clk) begin : result_check
		seed_total_t due;
		if (arst_n && out_valid && out_ready) begin
			if (best_totals_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: total %0h, error %0b",
					min_total_frequency, config_error));
			end else begin
				due = best_totals_due.pop_front();
				if (min_total_frequency !== due.total)
					report_mismatch($sformatf("min_total_frequency %0h, expected %0h",
						min_total_frequency, due.total));
				if (config_error !== due.err)
					report_mismatch($sformatf("config_error %0b, expected %0b",
						config_error, due.err));
			end
		end
	end

	// Ends a run that hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
